// ===== rtl/bitmap_linked_block_allocator_core_macros.svh =====
// ----------------------------------------------------------------------------
// allocator assertion macros
// shared concurrent assertion shorthands, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef BITMAP_LINKED_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_LINKED_BLOCK_ALLOCATOR_CORE_MACROS_SVH

// condition holds at every edge out of reset
`define BLA_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BLA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/bla_pkg.sv =====
// ----------------------------------------------------------------------------
// bla_pkg
// shared types, field widths and codes of the linked block allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bla_pkg;

  localparam int NUM_BLOCKS_DEF = 128;
  localparam int NUM_SLOTS_DEF  = 16;

  localparam int CMD_W    = 3;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 8;
  localparam int BIDX_W   = 7;
  localparam int STATUS_W = 2;
  localparam int BNUM_W   = 7;

  // command codes
  localparam logic [CMD_W-1:0] OP_ALLOC      = 3'd0;
  localparam logic [CMD_W-1:0] OP_DELETE     = 3'd1;
  localparam logic [CMD_W-1:0] OP_SET_STATE  = 3'd2;
  localparam logic [CMD_W-1:0] OP_READ_BLOCK = 3'd3;
  localparam logic [CMD_W-1:0] OP_READ_SLOT  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IN_USE  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [SLOT_W-1:0]  file_slot;
    logic [COUNT_W-1:0] block_count;
    logic [BIDX_W-1:0]  block_index;
    logic               block_is_free;
  } bla_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BNUM_W-1:0]   start_block;
    logic [BNUM_W-1:0]   end_block;
    logic                slot_valid;
    logic                block_free_out;
  } bla_out_t;

  // which result the output register is loaded with
  typedef enum logic [3:0] {
    RES_ZERO,
    RES_EMPTY,
    RES_IN_USE,
    RES_NO_ROOM,
    RES_SLOT,
    RES_DEL,
    RES_ALLOC,
    RES_SET,
    RES_READ
  } bla_res_t;

  // controller to datapath
  typedef struct packed {
    logic     latch_in;
    logic     clr_step;
    logic     scan_init;
    logic     scan_step;
    logic     alloc_end;
    logic     walk_start;
    logic     walk_step;
    logic     slot_clear;
    logic     set_write;
    logic     out_load;
    bla_res_t res_kind;
  } bla_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             clr_last;
    logic [CMD_W-1:0] op;
    logic             slot_ok;
    logic             slot_in_use;
    logic             blk_ok;
    logic             room_ok;
    logic             count_zero;
    logic             len_zero;
    logic             take_last;
    logic             walk_last;
    logic             out_free;
  } bla_sts_t;

endpackage

// ===== rtl/bla_ctrl.sv =====
// ----------------------------------------------------------------------------
// bla_ctrl
// sequencer of the allocator: clearing pass, decode, scan, chain walk, reply
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bla_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bla_pkg::bla_sts_t sts,
  output bla_pkg::bla_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_SCAN,
    S_ALLOC_END,
    S_WALK,
    S_DEL_END,
    S_RESP
  } state_t;

  state_t            state_r, state_nxt;
  bla_pkg::bla_res_t res_kind_r, res_kind_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    res_kind_nxt = res_kind_r;
    cmd          = '0;
    cmd.res_kind = res_kind_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_RESP;
        case (sts.op)
          bla_pkg::OP_ALLOC: begin
            if (!sts.slot_ok) begin
              res_kind_nxt = bla_pkg::RES_EMPTY;
            end else if (sts.slot_in_use) begin
              res_kind_nxt = bla_pkg::RES_IN_USE;
            end else if (!sts.room_ok) begin
              res_kind_nxt = bla_pkg::RES_NO_ROOM;
            end else begin
              cmd.scan_init = 1'b1;
              state_nxt     = sts.count_zero ? S_ALLOC_END : S_SCAN;
            end
          end
          bla_pkg::OP_DELETE: begin
            if (!sts.slot_ok || !sts.slot_in_use) begin
              res_kind_nxt = bla_pkg::RES_EMPTY;
            end else if (sts.len_zero) begin
              state_nxt = S_DEL_END;
            end else begin
              cmd.walk_start = 1'b1;
              state_nxt      = S_WALK;
            end
          end
          bla_pkg::OP_SET_STATE: begin
            if (sts.blk_ok) begin
              cmd.set_write = 1'b1;
              res_kind_nxt  = bla_pkg::RES_SET;
            end else begin
              res_kind_nxt = bla_pkg::RES_ZERO;
            end
          end
          bla_pkg::OP_READ_BLOCK: begin
            res_kind_nxt = sts.blk_ok ? bla_pkg::RES_READ : bla_pkg::RES_ZERO;
          end
          bla_pkg::OP_READ_SLOT: begin
            res_kind_nxt = (sts.slot_ok && sts.slot_in_use) ? bla_pkg::RES_SLOT
                                                             : bla_pkg::RES_EMPTY;
          end
          default: begin
            res_kind_nxt = bla_pkg::RES_ZERO;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.take_last) begin
          state_nxt = S_ALLOC_END;
        end
      end
      S_ALLOC_END: begin
        cmd.alloc_end = 1'b1;
        res_kind_nxt  = bla_pkg::RES_ALLOC;
        state_nxt     = S_RESP;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_last) begin
          state_nxt = S_DEL_END;
        end
      end
      S_DEL_END: begin
        cmd.slot_clear = 1'b1;
        res_kind_nxt   = bla_pkg::RES_DEL;
        state_nxt      = S_RESP;
      end
      S_RESP: begin
        cmd.out_load = sts.out_free;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      res_kind_r <= bla_pkg::RES_ZERO;
    end else begin
      state_r    <= state_nxt;
      res_kind_r <= res_kind_nxt;
    end
  end

endmodule

// ===== rtl/bla_dp.sv =====
// ----------------------------------------------------------------------------
// bla_dp
// datapath: free map, link and directory memories, counters, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bitmap_linked_block_allocator_core_macros.svh"

module bla_dp #(
  parameter int NUM_BLOCKS = bla_pkg::NUM_BLOCKS_DEF,
  parameter int NUM_SLOTS  = bla_pkg::NUM_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bla_pkg::bla_in_t  in_data,
  input  bla_pkg::bla_cmd_t cmd,
  output bla_pkg::bla_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output bla_pkg::bla_out_t out_data
);

  localparam int BW  = $clog2(NUM_BLOCKS);
  localparam int SW  = $clog2(NUM_SLOTS);
  localparam int CW  = $clog2(NUM_BLOCKS + 1);
  localparam int BXW = (BW > bla_pkg::BIDX_W) ? BW : bla_pkg::BIDX_W;
  localparam int SXW = (SW > bla_pkg::SLOT_W) ? SW : bla_pkg::SLOT_W;
  localparam int RW  = (CW > bla_pkg::COUNT_W) ? CW : bla_pkg::COUNT_W;
  localparam int NW  = bla_pkg::COUNT_W;

  // storage
  logic          fm_mem [NUM_BLOCKS];
  logic [BW-1:0] nl_mem [NUM_BLOCKS];
  logic [BW-1:0] tf_mem [NUM_SLOTS];
  logic [BW-1:0] tl_mem [NUM_SLOTS];
  logic [NW-1:0] tn_mem [NUM_SLOTS];

  bla_pkg::bla_in_t in_r;
  logic [BW-1:0]    clr_a_r, clr_a_nxt;
  logic [CW-1:0]    free_cnt_r, free_cnt_nxt;
  logic [NUM_SLOTS-1:0] slot_used_r, slot_used_nxt;

  // scan and walk registers
  logic [BW-1:0] scan_a_r, pend_a_r, first_r, last_r, wk_a_r;
  logic          pend_r, hit_r;
  logic [NW-1:0] taken_r, k_r;

  // registered read data
  logic          fm_rd_r;
  logic [BW-1:0] nl_rd_r, tf_rd_r, tl_rd_r;
  logic [NW-1:0] tn_rd_r;

  logic              out_valid_r, out_valid_nxt;
  bla_pkg::bla_out_t out_data_r, res;

  // decode of the held beat
  logic [BXW:0]  blk_x;
  logic [SXW:0]  slot_x;
  logic [BW-1:0] bidx;
  logic [SW-1:0] sidx;
  logic          blk_ok, slot_ok;

  assign blk_x   = (BXW + 1)'(in_r.block_index);
  assign slot_x  = (SXW + 1)'(in_r.file_slot);
  assign bidx    = blk_x[BW-1:0];
  assign sidx    = slot_x[SW-1:0];
  assign blk_ok  = blk_x < (BXW + 1)'(NUM_BLOCKS);
  assign slot_ok = slot_x < (SXW + 1)'(NUM_SLOTS);

  logic scan_take, walk_inc, set_inc, set_dec;

  assign scan_take = cmd.scan_step && pend_r && fm_rd_r;
  assign walk_inc  = cmd.walk_step && !(fm_rd_r || hit_r);
  assign set_inc   = cmd.set_write && in_r.block_is_free && !fm_rd_r;
  assign set_dec   = cmd.set_write && !in_r.block_is_free && fm_rd_r;

  // memory port selection
  logic [BW-1:0] fm_ra, fm_wa, nl_ra, nl_wa, nl_wd;
  logic          fm_we, fm_wd, nl_we;

  always_comb begin
    fm_ra = bidx;
    nl_ra = wk_a_r;
    if (cmd.scan_step) begin
      fm_ra = scan_a_r;
    end
    if (cmd.walk_start) begin
      fm_ra = tf_rd_r;
      nl_ra = tf_rd_r;
    end
    if (cmd.walk_step) begin
      fm_ra = nl_rd_r;
      nl_ra = nl_rd_r;
    end
  end

  always_comb begin
    fm_we = 1'b0;
    fm_wa = bidx;
    fm_wd = 1'b1;
    if (cmd.clr_step) begin
      fm_we = 1'b1;
      fm_wa = clr_a_r;
    end else if (scan_take) begin
      fm_we = 1'b1;
      fm_wa = pend_a_r;
      fm_wd = 1'b0;
    end else if (cmd.walk_step) begin
      fm_we = 1'b1;
      fm_wa = wk_a_r;
    end else if (cmd.set_write) begin
      fm_we = 1'b1;
      fm_wd = in_r.block_is_free;
    end
  end

  // chain link of the previous block, or the self link closing the chain
  assign nl_we = (scan_take || cmd.alloc_end) && (taken_r != '0);
  assign nl_wa = last_r;
  assign nl_wd = scan_take ? pend_a_r : last_r;

  always_ff @(posedge clk) begin
    if (fm_we) begin
      fm_mem[fm_wa] <= fm_wd;
    end
    fm_rd_r <= fm_mem[fm_ra];
  end

  always_ff @(posedge clk) begin
    if (nl_we) begin
      nl_mem[nl_wa] <= nl_wd;
    end
    nl_rd_r <= nl_mem[nl_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_end) begin
      tf_mem[sidx] <= first_r;
      tl_mem[sidx] <= last_r;
      tn_mem[sidx] <= in_r.block_count;
    end
    tf_rd_r <= tf_mem[sidx];
    tl_rd_r <= tl_mem[sidx];
    tn_rd_r <= tn_mem[sidx];
  end

  // control state
  always_comb begin
    clr_a_nxt = cmd.clr_step ? clr_a_r + BW'(1) : clr_a_r;
    free_cnt_nxt = free_cnt_r;
    if (walk_inc || set_inc) begin
      free_cnt_nxt = free_cnt_r + CW'(1);
    end else if (scan_take || set_dec) begin
      free_cnt_nxt = free_cnt_r - CW'(1);
    end
    slot_used_nxt = slot_used_r;
    if (cmd.alloc_end) begin
      slot_used_nxt[sidx] = 1'b1;
    end else if (cmd.slot_clear) begin
      slot_used_nxt[sidx] = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_a_r     <= '0;
      free_cnt_r  <= CW'(NUM_BLOCKS);
      slot_used_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_a_r     <= clr_a_nxt;
      free_cnt_r  <= free_cnt_nxt;
      slot_used_r <= slot_used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_r <= in_data;
    end
    if (cmd.scan_init) begin
      scan_a_r <= '0;
      pend_r   <= 1'b0;
      taken_r  <= '0;
      first_r  <= '0;
      last_r   <= '0;
    end else if (cmd.scan_step) begin
      scan_a_r <= scan_a_r + BW'(1);
      pend_r   <= 1'b1;
      pend_a_r <= scan_a_r;
      if (scan_take) begin
        if (taken_r == '0) begin
          first_r <= pend_a_r;
        end
        last_r  <= pend_a_r;
        taken_r <= taken_r + NW'(1);
      end
    end
    if (cmd.walk_start) begin
      wk_a_r <= tf_rd_r;
      k_r    <= NW'(1);
      hit_r  <= 1'b0;
    end else if (cmd.walk_step && (k_r != tn_rd_r)) begin
      wk_a_r <= nl_rd_r;
      k_r    <= k_r + NW'(1);
      // same block read while it is being freed: old data is stale
      hit_r  <= (nl_rd_r == wk_a_r);
    end
  end

  // block numbers go out on the fixed 7-bit fields
  logic [BXW-1:0] tf_x, tl_x, first_x, last_x;

  assign tf_x    = BXW'(tf_rd_r);
  assign tl_x    = BXW'(tl_rd_r);
  assign first_x = BXW'(first_r);
  assign last_x  = BXW'(last_r);

  always_comb begin
    res = '0;
    case (cmd.res_kind)
      bla_pkg::RES_ZERO: begin
        res = '0;
      end
      bla_pkg::RES_EMPTY: begin
        res.status = bla_pkg::ST_EMPTY;
      end
      bla_pkg::RES_NO_ROOM: begin
        res.status = bla_pkg::ST_NO_ROOM;
      end
      bla_pkg::RES_IN_USE: begin
        res.status      = bla_pkg::ST_IN_USE;
        res.start_block = tf_x[bla_pkg::BNUM_W-1:0];
        res.end_block   = tl_x[bla_pkg::BNUM_W-1:0];
        res.slot_valid  = 1'b1;
      end
      bla_pkg::RES_SLOT: begin
        res.status      = bla_pkg::ST_OK;
        res.start_block = tf_x[bla_pkg::BNUM_W-1:0];
        res.end_block   = tl_x[bla_pkg::BNUM_W-1:0];
        res.slot_valid  = 1'b1;
      end
      bla_pkg::RES_DEL: begin
        res.status      = bla_pkg::ST_OK;
        res.start_block = tf_x[bla_pkg::BNUM_W-1:0];
        res.end_block   = tl_x[bla_pkg::BNUM_W-1:0];
      end
      bla_pkg::RES_ALLOC: begin
        res.status      = bla_pkg::ST_OK;
        res.start_block = first_x[bla_pkg::BNUM_W-1:0];
        res.end_block   = last_x[bla_pkg::BNUM_W-1:0];
        res.slot_valid  = 1'b1;
      end
      bla_pkg::RES_SET: begin
        res.status         = bla_pkg::ST_OK;
        res.block_free_out = in_r.block_is_free;
      end
      bla_pkg::RES_READ: begin
        res.status         = bla_pkg::ST_OK;
        res.block_free_out = fm_rd_r;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // status to the controller
  always_comb begin
    sts             = '0;
    sts.clr_last    = (clr_a_r == BW'(NUM_BLOCKS - 1));
    sts.op          = in_r.command;
    sts.slot_ok     = slot_ok;
    sts.slot_in_use = slot_ok && slot_used_r[sidx];
    sts.blk_ok      = blk_ok;
    sts.room_ok     = RW'(free_cnt_r) >= RW'(in_r.block_count);
    sts.count_zero  = (in_r.block_count == '0);
    sts.len_zero    = (tn_rd_r == '0);
    sts.take_last   = scan_take && ((taken_r + NW'(1)) == in_r.block_count);
    sts.walk_last   = (k_r == tn_rd_r);
    sts.out_free    = !out_valid_r || out_ready;
  end

  `BLA_ASSERT_ALWAYS(a_free_cnt_range, free_cnt_r <= CW'(NUM_BLOCKS), "free count above block total")
  `BLA_ASSERT_IMPLY(a_scan_take_bound, scan_take, taken_r < in_r.block_count, "scan took too many blocks")
  `BLA_ASSERT_IMPLY(a_fm_write_range, fm_we, (BW + 1)'(fm_wa) < (BW + 1)'(NUM_BLOCKS), "free map write out of range")
  `BLA_ASSERT_IMPLY(a_walk_inc_room, walk_inc, free_cnt_r < CW'(NUM_BLOCKS), "walk freed an already free block")

endmodule

// ===== rtl/bitmap_linked_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_linked_block_allocator_core
// linked file allocation over a free-block bitmap with a slot directory
// ----------------------------------------------------------------------------
//   channel  ports                         payload
//   in       in_valid / in_ready           in_data   (bla_pkg::bla_in_t)
//   out      out_valid / out_ready         out_data  (bla_pkg::bla_out_t)
//
// one beat in gives one beat out; one command is worked on at a time
// set state, read block, read slot and refused commands: decode, execute, then the result
// allocate: decode, execute, then the bitmap scan, one block per cycle up to the
//   highest block taken, set by the free map port
// delete: decode, execute, then one chain link per cycle (file length), link memory
// after reset a clearing pass over all NUM_BLOCKS blocks marks every block free;
//   in_ready stays low meanwhile
// a result waiting on out_ready holds the next command back only at its end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_linked_block_allocator_core #(
  parameter int NUM_BLOCKS = bla_pkg::NUM_BLOCKS_DEF,
  parameter int NUM_SLOTS  = bla_pkg::NUM_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // command beats
  input  logic              in_valid,
  output logic              in_ready,
  input  bla_pkg::bla_in_t  in_data,
  // result beats
  output logic              out_valid,
  input  logic              out_ready,
  output bla_pkg::bla_out_t out_data
);

  // controller and datapath talk only through these two bundles
  bla_pkg::bla_cmd_t cmd;
  bla_pkg::bla_sts_t sts;

  // sequencer: clear, decode, scan or walk, then hand over the result
  bla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // free map, chain links, directory and the output register
  bla_dp #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .NUM_SLOTS  (NUM_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the linked block allocator: directed and random
// commands go in over valid/ready, a tracker predicts each result beat from
// its own copy of the bitmap, links and slot directory, and compares them
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import bla_pkg::*;

class block_alloc_tracker;
  bit               blk_free   [NUM_BLOCKS_DEF];
  bit [BNUM_W-1:0]  blk_link   [NUM_BLOCKS_DEF];
  bit               file_used  [NUM_SLOTS_DEF];
  bit [BNUM_W-1:0]  file_first [NUM_SLOTS_DEF];
  bit [BNUM_W-1:0]  file_last  [NUM_SLOTS_DEF];
  bit [COUNT_W-1:0] file_len   [NUM_SLOTS_DEF];
  bla_out_t         expected_results [$];
  int               failures;

  function new();
    foreach (blk_free[i]) blk_free[i] = 1'b1;
    failures = 0;
  endfunction

  function int free_blocks();
    int n;
    n = 0;
    foreach (blk_free[i]) n += int'(blk_free[i]);
    return n;
  endfunction

  // every 4-bit slot and 7-bit index is in range at the default sizes
  function bla_out_t predict_result(bla_in_t c);
    bla_out_t r;
    int       i;
    int       taken;
    int       prev;
    int       cur;
    r = '0;
    case (c.command)
      OP_ALLOC: begin
        if (file_used[c.file_slot]) begin
          r.status      = ST_IN_USE;
          r.start_block = file_first[c.file_slot];
          r.end_block   = file_last[c.file_slot];
          r.slot_valid  = 1'b1;
        end else if (free_blocks() < c.block_count) begin
          r.status = ST_NO_ROOM;
        end else begin
          taken = 0;
          prev  = 0;
          file_first[c.file_slot] = '0;
          file_last[c.file_slot]  = '0;
          // first fit from block 0, chained in ascending order
          for (i = 0; i < NUM_BLOCKS_DEF && taken < c.block_count; i++) begin
            if (blk_free[i]) begin
              blk_free[i] = 1'b0;
              blk_link[i] = BNUM_W'(i);
              if (taken == 0) file_first[c.file_slot] = BNUM_W'(i);
              else blk_link[prev] = BNUM_W'(i);
              prev = i;
              taken++;
            end
          end
          if (taken > 0) file_last[c.file_slot] = BNUM_W'(prev);
          file_len[c.file_slot]  = c.block_count;
          file_used[c.file_slot] = 1'b1;
          r.status      = ST_OK;
          r.start_block = file_first[c.file_slot];
          r.end_block   = file_last[c.file_slot];
          r.slot_valid  = 1'b1;
        end
      end
      OP_DELETE: begin
        if (!file_used[c.file_slot]) begin
          r.status = ST_EMPTY;
        end else begin
          // walk the links as they stand now, for the recorded length
          cur = int'(file_first[c.file_slot]);
          for (i = 0; i < file_len[c.file_slot] && i < NUM_BLOCKS_DEF; i++) begin
            blk_free[cur] = 1'b1;
            cur = int'(blk_link[cur]);
          end
          file_used[c.file_slot] = 1'b0;
          r.status      = ST_OK;
          r.start_block = file_first[c.file_slot];
          r.end_block   = file_last[c.file_slot];
        end
      end
      OP_SET_STATE: begin
        blk_free[c.block_index] = c.block_is_free;
        r.block_free_out = c.block_is_free;
      end
      OP_READ_BLOCK: r.block_free_out = blk_free[c.block_index];
      OP_READ_SLOT: begin
        if (file_used[c.file_slot]) begin
          r.start_block = file_first[c.file_slot];
          r.end_block   = file_last[c.file_slot];
          r.slot_valid  = 1'b1;
        end else begin
          r.status = ST_EMPTY;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function void note_command(bla_in_t c);
    expected_results.push_back(predict_result(c));
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  function void check_result(bla_out_t got);
    bla_out_t want;
    if (expected_results.size() == 0) begin
      $error("result beat with nothing outstanding: %h", got);
      failures++;
      return;
    end
    want = expected_results.pop_front();
    compare_field("status", 8'(want.status), 8'(got.status));
    compare_field("start_block", 8'(want.start_block), 8'(got.start_block));
    compare_field("end_block", 8'(want.end_block), 8'(got.end_block));
    compare_field("slot_valid", 8'(want.slot_valid), 8'(got.slot_valid));
    compare_field("block_free_out", 8'(want.block_free_out), 8'(got.block_free_out));
  endfunction

  // a slot in the wanted state if there is one, else any slot
  function int slot_pick(bit want_used);
    int s;
    int i;
    s = $urandom_range(NUM_SLOTS_DEF - 1);
    for (i = 0; i < NUM_SLOTS_DEF; i++) begin
      if (file_used[(s + i) % NUM_SLOTS_DEF] == want_used) return (s + i) % NUM_SLOTS_DEF;
    end
    return s;
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 500;
  localparam int IN_W         = $bits(bla_in_t);
  // slowest command scans the whole bitmap
  localparam int DRAIN_CYCLES = NUM_BLOCKS_DEF + 32;
  localparam logic [CMD_W-1:0] OP_FIRST_UNUSED = OP_READ_SLOT + 1'b1;
  localparam logic [CMD_W-1:0] OP_LAST_UNUSED  = {CMD_W{1'b1}};

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  bla_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  bla_out_t    out_data;
  bit          calm      = 1'b0;
  int unsigned cycles    = 0;

  block_alloc_tracker tracker = new();

  bitmap_linked_block_allocator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // result side: random back-pressure, every accepted beat checked in order
  always @(posedge clk) begin
    if (rst_n) out_ready <= calm || ($urandom_range(99) >= 20);
    if (rst_n && out_valid && out_ready) tracker.check_result(out_data);
  end

  function bla_in_t make_cmd(logic [CMD_W-1:0] op, int slot, int count, int idx,
                             bit free_flag);
    bla_in_t c;
    c               = '0;
    c.command       = op;
    c.file_slot     = SLOT_W'(slot);
    c.block_count   = COUNT_W'(count);
    c.block_index   = BIDX_W'(idx);
    c.block_is_free = free_flag;
    return c;
  endfunction

  // mostly well-formed traffic: allocate into empty slots, delete used ones
  function bla_in_t random_cmd();
    bla_in_t c;
    int      pick;
    c    = IN_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) begin
      c.command = OP_ALLOC;
      if ($urandom_range(9) < 8) c.file_slot = SLOT_W'(tracker.slot_pick(1'b0));
      pick = $urandom_range(99);
      if (pick < 80) c.block_count = COUNT_W'($urandom_range(12));
      else if (pick < 95) c.block_count = COUNT_W'($urandom_range(13, NUM_BLOCKS_DEF));
      else c.block_count = COUNT_W'($urandom_range(NUM_BLOCKS_DEF + 1, 255));
    end else if (pick < 55) begin
      c.command = OP_DELETE;
      if ($urandom_range(9) < 8) c.file_slot = SLOT_W'(tracker.slot_pick(1'b1));
    end else if (pick < 65) begin
      c.command       = OP_SET_STATE;
      c.block_is_free = ($urandom_range(99) < 65);
    end else if (pick < 80) begin
      c.command = OP_READ_BLOCK;
    end else if (pick < 96) begin
      c.command = OP_READ_SLOT;
      if ($urandom_range(1)) c.file_slot = SLOT_W'(tracker.slot_pick(1'b1));
    end else begin
      c.command = CMD_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    end
    return c;
  endfunction

  // one command beat, with a random gap ahead of it unless calm
  task automatic send_cmd(bla_in_t c);
    if (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 20);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (!in_ready);
    tracker.note_command(c);
  endtask

  // hold the sender off until every outstanding result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  initial begin
    int n_items;
    int iter;
    bla_in_t c;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty reads, full-size file, zero-length file, refusals
    send_cmd(make_cmd(OP_READ_BLOCK, 0, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_READ_BLOCK, 0, 0, 127, 1'b0));
    send_cmd(make_cmd(OP_READ_SLOT, 15, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_DELETE, 3, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_ALLOC, 7, NUM_BLOCKS_DEF, 0, 1'b0));
    send_cmd(make_cmd(OP_ALLOC, 8, 1, 0, 1'b0));
    send_cmd(make_cmd(OP_READ_SLOT, 7, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_DELETE, 7, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_ALLOC, 0, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_READ_SLOT, 0, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_DELETE, 0, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_ALLOC, 1, 5, 0, 1'b0));
    send_cmd(make_cmd(OP_ALLOC, 1, 3, 0, 1'b0));
    send_cmd(make_cmd(OP_ALLOC, 2, 255, 0, 1'b0));
    // freeing a block inside a live file, then handing it to another file,
    // bends the first file's chain into the second
    send_cmd(make_cmd(OP_SET_STATE, 0, 0, 2, 1'b1));
    send_cmd(make_cmd(OP_SET_STATE, 0, 0, 127, 1'b0));
    send_cmd(make_cmd(OP_SET_STATE, 0, 0, 64, 1'b0));
    send_cmd(make_cmd(OP_READ_BLOCK, 0, 0, 2, 1'b0));
    send_cmd(make_cmd(OP_ALLOC, 15, 122, 0, 1'b0));
    send_cmd(make_cmd(OP_DELETE, 1, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_FIRST_UNUSED, 15, 255, 127, 1'b1));
    send_cmd(make_cmd(OP_FIRST_UNUSED + 1'b1, 15, 255, 127, 1'b1));
    send_cmd(make_cmd(OP_LAST_UNUSED, 15, 255, 127, 1'b1));
    send_cmd(make_cmd(OP_DELETE, 15, 0, 0, 1'b0));
    send_cmd(make_cmd(OP_SET_STATE, 0, 0, 127, 1'b1));
    send_cmd(make_cmd(OP_SET_STATE, 0, 0, 64, 1'b1));
    wait_idle();

    // random traffic, with a calm stretch and a drain now and then
    n_items = 0;
    iter    = 0;
    while (n_items < RANDOM_ITEMS) begin
      calm <= (iter >= 200 && iter < 320);
      if (iter % 100 == 50) wait_idle();
      c = random_cmd();
      send_cmd(c);
      if (c.command < OP_FIRST_UNUSED) n_items++;
      iter++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
